### rtl/dcspi_pkg.sv
// ----------------------------------------------------------------------------
// dcspi_pkg
// Shared widths, constants and register codes for the two-channel speed
// PID controller.
// ----------------------------------------------------------------------------
package dcspi_pkg;

  localparam int CHANNELS       = 2;
  localparam int CH_W           = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int GAIN_FRAC_BITS = 8;

  localparam int FUNC_W  = 1;
  localparam int SPEED_W = 16;
  localparam int DRIVE_W = 8;
  localparam int GAIN_W  = 12;
  localparam int BIAS_W  = 8;
  localparam int ERR_W   = SPEED_W + 1;
  localparam int DIFF_W  = ERR_W + 1;
  localparam int INTEG_W = 24;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = GAIN_W;

  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 8'sd100;
  localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = -8'sd100;
  localparam logic signed [INTEG_W-1:0] INTEG_CLIP = 24'sd100;

  localparam logic [GAIN_W-1:0] GAIN_P_RST = 12'd640;
  localparam logic [GAIN_W-1:0] GAIN_I_RST = 12'd179;
  localparam logic [GAIN_W-1:0] GAIN_D_RST = 12'd0;
  localparam logic signed [BIAS_W-1:0] BIAS_FIRST_RST  = 8'sd0;
  localparam logic signed [BIAS_W-1:0] BIAS_SECOND_RST = 8'sd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P      = 3'd0,
    REG_GAIN_I      = 3'd1,
    REG_GAIN_D      = 3'd2,
    REG_BIAS_FIRST  = 3'd3,
    REG_BIAS_SECOND = 3'd4
  } cfg_reg_t;

endpackage

### rtl/dcspi_if.sv
// ----------------------------------------------------------------------------
// dcspi_if
// Valid/ready channels of the speed PID controller: speed samples in,
// drive commands out.
// ----------------------------------------------------------------------------
interface dcspi_in_if;
  logic                                      valid;
  logic                                      ready;
  logic [dcspi_pkg::FUNC_W-1:0]              func;
  logic signed [dcspi_pkg::SPEED_W-1:0]      speed;
  logic signed [dcspi_pkg::SPEED_W-1:0]      target;

  modport source (output valid, output func, output speed, output target, input ready);
  modport sink   (input valid, input func, input speed, input target, output ready);
endinterface

interface dcspi_out_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [dcspi_pkg::DRIVE_W-1:0]      drive;

  modport source (output valid, output drive, input ready);
  modport sink   (input valid, input drive, output ready);
endinterface

### rtl/dual_channel_speed_pi_controller_unit.sv
// ----------------------------------------------------------------------------
// dual_channel_speed_pi_controller_unit
// Two-channel positional PID speed loop with integral clip and drive clamp.
// ----------------------------------------------------------------------------
// Each transfer on in_ch names a channel and carries a measured speed and a
// target; one drive command in -100..100 comes back on out_ch for each one,
// in order. It takes one sample per clock cycle unless out_ch stalls; each
// sample passes the input register, then the result register. The
// per-channel integral and error history are read, used and written back
// between the two registers, so a sample on the same channel may follow in
// the very next cycle. The result register frees the input side while a
// drive waits on out_ch.ready. The user must write gains and biases through
// cfg_we/cfg_idx/cfg_wdata only while idle; the block does not enforce it.
module dual_channel_speed_pi_controller_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  dcspi_in_if.sink                           in_ch,
  dcspi_out_if.source                        out_ch,
  input  logic                               cfg_we,
  input  logic [dcspi_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [dcspi_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int FB     = dcspi_pkg::GAIN_FRAC_BITS;
  localparam int ERR_W  = dcspi_pkg::ERR_W;
  localparam int DIFF_W = dcspi_pkg::DIFF_W;
  localparam int INT_W  = dcspi_pkg::INTEG_W;
  localparam int G_W    = dcspi_pkg::GAIN_W;
  localparam int P_W    = G_W + 1 + ERR_W;
  localparam int I_W    = G_W + 1 + INT_W;
  localparam int D_W    = G_W + 1 + DIFF_W;
  localparam int ACC_W  = I_W + 2;

  // configuration registers
  logic [G_W-1:0]                            gain_p_r, gain_i_r, gain_d_r;
  logic signed [dcspi_pkg::BIAS_W-1:0]       bias_first_r, bias_second_r;

  // input register
  logic                                      in_valid_r;
  logic [dcspi_pkg::FUNC_W-1:0]              func_r;
  logic signed [dcspi_pkg::SPEED_W-1:0]      speed_r, target_r;

  // result register
  logic                                      out_valid_r;
  logic signed [dcspi_pkg::DRIVE_W-1:0]      drive_r, drive_nxt;

  // per-channel loop state
  logic signed [INT_W-1:0]                   integ_r [dcspi_pkg::CHANNELS];
  logic signed [ERR_W-1:0]                   last_err_r [dcspi_pkg::CHANNELS];
  logic signed [ERR_W-1:0]                   prior_err_r [dcspi_pkg::CHANNELS];

  logic                                      advance;
  logic [dcspi_pkg::CH_W-1:0]                ch;
  logic signed [ERR_W-1:0]                   err;
  logic signed [INT_W-1:0]                   integ_cur, integ_clip, integ_nxt;
  logic signed [INT_W:0]                     integ_sum;
  logic signed [DIFF_W-1:0]                  diff;
  logic signed [P_W-1:0]                     prod_p;
  logic signed [I_W-1:0]                     prod_i;
  logic signed [D_W-1:0]                     prod_d;
  logic signed [dcspi_pkg::BIAS_W-1:0]       bias;
  logic signed [ACC_W-1:0]                   acc, quot;

  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;
  assign out_ch.valid = out_valid_r;
  assign out_ch.drive = drive_r;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r      <= dcspi_pkg::GAIN_P_RST;
      gain_i_r      <= dcspi_pkg::GAIN_I_RST;
      gain_d_r      <= dcspi_pkg::GAIN_D_RST;
      bias_first_r  <= dcspi_pkg::BIAS_FIRST_RST;
      bias_second_r <= dcspi_pkg::BIAS_SECOND_RST;
    end else if (cfg_we) begin
      case (dcspi_pkg::cfg_reg_t'(cfg_idx))
        dcspi_pkg::REG_GAIN_P:      gain_p_r      <= cfg_wdata;
        dcspi_pkg::REG_GAIN_I:      gain_i_r      <= cfg_wdata;
        dcspi_pkg::REG_GAIN_D:      gain_d_r      <= cfg_wdata;
        dcspi_pkg::REG_BIAS_FIRST:  bias_first_r  <= $signed(cfg_wdata[dcspi_pkg::BIAS_W-1:0]);
        dcspi_pkg::REG_BIAS_SECOND: bias_second_r <= $signed(cfg_wdata[dcspi_pkg::BIAS_W-1:0]);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- compute
  always_comb begin
    if (dcspi_pkg::CHANNELS > 1) begin
      ch = dcspi_pkg::CH_W'(func_r % dcspi_pkg::CHANNELS);
    end else begin
      ch = '0;
    end
    err  = ERR_W'(target_r) - ERR_W'(speed_r);
    bias = (ch == '0) ? bias_first_r : bias_second_r;

    integ_cur  = integ_r[ch];
    integ_clip = (integ_cur > dcspi_pkg::INTEG_CLIP) ? dcspi_pkg::INTEG_CLIP : integ_cur;
    diff       = DIFF_W'(last_err_r[ch]) - DIFF_W'(prior_err_r[ch]);

    prod_p = $signed({1'b0, gain_p_r}) * err;
    prod_i = $signed({1'b0, gain_i_r}) * integ_clip;
    prod_d = $signed({1'b0, gain_d_r}) * diff;

    acc = ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d)
        + ACC_W'($signed({bias, {FB{1'b0}}}));

    // divide by the gain scale, truncating toward zero
    quot = acc >>> FB;
    if (acc[ACC_W-1] && (acc[FB-1:0] != '0)) begin
      quot = quot + ACC_W'(1);
    end

    if (quot > ACC_W'(dcspi_pkg::DRIVE_MAX)) begin
      drive_nxt = dcspi_pkg::DRIVE_MAX;
    end else if (quot < ACC_W'(dcspi_pkg::DRIVE_MIN)) begin
      drive_nxt = dcspi_pkg::DRIVE_MIN;
    end else begin
      drive_nxt = quot[dcspi_pkg::DRIVE_W-1:0];
    end

    // accumulate, saturating to the integral's range
    integ_sum = (INT_W + 1)'(integ_clip) + (INT_W + 1)'(err);
    if (integ_sum[INT_W] != integ_sum[INT_W-1]) begin
      integ_nxt = integ_sum[INT_W] ? {1'b1, {(INT_W-1){1'b0}}} : {1'b0, {(INT_W-1){1'b1}}};
    end else begin
      integ_nxt = integ_sum[INT_W-1:0];
    end
  end

  // ---------------------------------------------------------------- pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      func_r   <= in_ch.func;
      speed_r  <= in_ch.speed;
      target_r <= in_ch.target;
    end
    if (advance) begin
      drive_r <= drive_nxt;
    end
  end

  // update the channel's history as its result is taken into the output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < dcspi_pkg::CHANNELS; c++) begin
        integ_r[c]     <= '0;
        last_err_r[c]  <= '0;
        prior_err_r[c] <= '0;
      end
    end else if (advance) begin
      integ_r[ch]     <= integ_nxt;
      last_err_r[ch]  <= err;
      prior_err_r[ch] <= last_err_r[ch];
    end
  end

`ifndef SYNTH
  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (drive_r <= dcspi_pkg::DRIVE_MAX && drive_r >= dcspi_pkg::DRIVE_MIN))
    else $error("drive outside clamp range");

  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("advanced item lost before the result register");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken while both stages are full");

  a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> (in_valid_r && $stable(speed_r) && $stable(target_r)))
    else $error("stalled input item changed");
`endif

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-channel speed PID controller. A short
// table of directed samples is followed by random samples under several
// gain/bias settings. Each drive is checked against a typed value or an
// in-bench model of the PID loop, with random gaps on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int    PIPE_LAT    = 2;
  localparam int    CYCLE_LIMIT = 400_000;
  localparam int    END_WAIT    = 2_000;
  localparam int    SHOWN_MAX   = 10;
  localparam logic  CH_FIRST    = 1'b0;
  localparam logic  CH_SECOND   = 1'b1;
  localparam logic [dcspi_pkg::CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [dcspi_pkg::CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;
  localparam logic signed [dcspi_pkg::SPEED_W-1:0] SPD_MIN = 16'sh8000;
  localparam logic signed [dcspi_pkg::SPEED_W-1:0] SPD_MAX = 16'sh7FFF;
  localparam longint INTEG_TOP = (longint'(1) <<< (dcspi_pkg::INTEG_W - 1)) - 1;
  localparam longint INTEG_BOT = -(longint'(1) <<< (dcspi_pkg::INTEG_W - 1));

  typedef struct packed {
    bit                                     known;
    logic                                   func;
    logic signed [dcspi_pkg::SPEED_W-1:0]   speed;
    logic signed [dcspi_pkg::SPEED_W-1:0]   target;
    logic signed [dcspi_pkg::DRIVE_W-1:0]   drive;
  } sample_row_t;

  // Reset gains: kp 2.5, ki 0.7, kd 0, bias 0 on the first channel, 1 on the second
  localparam int OPENING_ROWS = 15;
  sample_row_t opening_rows [OPENING_ROWS] = '{
    '{1'b1, CH_FIRST,  16'sd0,      16'sd0,      8'sd0},
    '{1'b1, CH_FIRST,  SPD_MIN,     SPD_MAX,     8'sd100},
    '{1'b1, CH_FIRST,  SPD_MAX,     SPD_MIN,     -8'sd100},
    '{1'b1, CH_SECOND, 16'sd0,      16'sd0,      8'sd1},
    '{1'b0, CH_SECOND, 16'sd10,     16'sd0,      8'sd0},
    '{1'b0, CH_SECOND, 16'sd0,      16'sd10,     8'sd0},
    '{1'b0, CH_SECOND, 16'sd0,      16'sd1,      8'sd0},
    '{1'b0, CH_SECOND, 16'sd1,      16'sd0,      8'sd0},
    '{1'b0, CH_FIRST,  16'sd0,      16'sd0,      8'sd0},
    '{1'b0, CH_FIRST,  -16'sd100,   16'sd100,    8'sd0},
    '{1'b0, CH_SECOND, SPD_MAX,     SPD_MAX,     8'sd0},
    '{1'b0, CH_FIRST,  SPD_MIN,     SPD_MIN,     8'sd0},
    '{1'b0, CH_SECOND, 16'sh5555,   16'shAAAA,   8'sd0},
    '{1'b0, CH_FIRST,  16'shAAAA,   16'sh5555,   8'sd0},
    '{1'b0, CH_SECOND, -16'sd1,     -16'sd1,     8'sd0}
  };

  logic                              clk;
  logic                              rst_n;
  logic                              cfg_we;
  logic [dcspi_pkg::CFG_IDX_W-1:0]   cfg_idx;
  logic [dcspi_pkg::CFG_DATA_W-1:0]  cfg_wdata;

  dcspi_in_if  in_if ();
  dcspi_out_if out_if ();

  dual_channel_speed_pi_controller_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if.sink),
    .out_ch    (out_if.source),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the controller's registers and per-channel loop state
  logic [dcspi_pkg::GAIN_W-1:0]          gain_p_q, gain_i_q, gain_d_q;
  logic signed [dcspi_pkg::BIAS_W-1:0]   bias_first_q, bias_second_q;
  logic signed [dcspi_pkg::INTEG_W-1:0]  integ_q  [dcspi_pkg::CHANNELS];
  logic signed [dcspi_pkg::ERR_W-1:0]    last_q   [dcspi_pkg::CHANNELS];
  logic signed [dcspi_pkg::ERR_W-1:0]    prior_q  [dcspi_pkg::CHANNELS];

  logic signed [dcspi_pkg::DRIVE_W-1:0]  drive_q [$];
  bit  tx_gaps, rx_gaps;
  int  mismatch_cnt, samples_sent, drives_checked, settings_cnt;
  int  clamp_hits, floor_hits, cycle_cnt;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic signed [dcspi_pkg::DRIVE_W-1:0] predict_drive(
      logic ch, logic signed [dcspi_pkg::SPEED_W-1:0] spd,
      logic signed [dcspi_pkg::SPEED_W-1:0] tgt);
    int     c;
    longint err, integ, bias, scale, acc, drv, sum;
    c     = int'(ch) % dcspi_pkg::CHANNELS;
    err   = longint'(tgt) - longint'(spd);
    bias  = (c == 0) ? longint'(bias_first_q) : longint'(bias_second_q);
    scale = longint'(1) <<< dcspi_pkg::GAIN_FRAC_BITS;
    // clip the stored integral before use and keep the clipped value
    integ = longint'(integ_q[c]);
    if (integ > longint'(dcspi_pkg::INTEG_CLIP)) integ = longint'(dcspi_pkg::INTEG_CLIP);
    acc = longint'(gain_p_q) * err
        + longint'(gain_i_q) * integ
        + longint'(gain_d_q) * (longint'(last_q[c]) - longint'(prior_q[c]))
        + bias * scale;
    drv = acc / scale;
    if (drv > longint'(dcspi_pkg::DRIVE_MAX) || drv < longint'(dcspi_pkg::DRIVE_MIN))
      clamp_hits++;
    if (drv > longint'(dcspi_pkg::DRIVE_MAX)) drv = longint'(dcspi_pkg::DRIVE_MAX);
    if (drv < longint'(dcspi_pkg::DRIVE_MIN)) drv = longint'(dcspi_pkg::DRIVE_MIN);
    prior_q[c] = last_q[c];
    last_q[c]  = err[dcspi_pkg::ERR_W-1:0];
    sum = integ + err;
    if (sum > INTEG_TOP) sum = INTEG_TOP;
    if (sum < INTEG_BOT) begin
      sum = INTEG_BOT;
      floor_hits++;
    end
    integ_q[c] = sum[dcspi_pkg::INTEG_W-1:0];
    return drv[dcspi_pkg::DRIVE_W-1:0];
  endfunction

  task automatic flag_error(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= SHOWN_MAX) $display("ERROR: %s", msg);
  endtask

  task automatic cfg_write(input logic [dcspi_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dcspi_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      dcspi_pkg::REG_GAIN_P:      gain_p_q      = data;
      dcspi_pkg::REG_GAIN_I:      gain_i_q      = data;
      dcspi_pkg::REG_GAIN_D:      gain_d_q      = data;
      dcspi_pkg::REG_BIAS_FIRST:  bias_first_q  = data[dcspi_pkg::BIAS_W-1:0];
      dcspi_pkg::REG_BIAS_SECOND: bias_second_q = data[dcspi_pkg::BIAS_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Bias writes carry junk in the upper nibble; only the low byte must stick
  task automatic apply_settings(input logic [dcspi_pkg::GAIN_W-1:0] gp,
                                input logic [dcspi_pkg::GAIN_W-1:0] gi,
                                input logic [dcspi_pkg::GAIN_W-1:0] gd,
                                input logic [dcspi_pkg::BIAS_W-1:0] b0,
                                input logic [dcspi_pkg::BIAS_W-1:0] b1);
    logic [dcspi_pkg::CFG_DATA_W-dcspi_pkg::BIAS_W-1:0] junk;
    cfg_write(dcspi_pkg::REG_GAIN_P, gp);
    cfg_write(dcspi_pkg::REG_GAIN_I, gi);
    cfg_write(dcspi_pkg::REG_GAIN_D, gd);
    junk = (dcspi_pkg::CFG_DATA_W - dcspi_pkg::BIAS_W)'($urandom);
    cfg_write(dcspi_pkg::REG_BIAS_FIRST, {junk, b0});
    junk = (dcspi_pkg::CFG_DATA_W - dcspi_pkg::BIAS_W)'($urandom);
    cfg_write(dcspi_pkg::REG_BIAS_SECOND, {junk, b1});
    settings_cnt++;
  endtask

  function automatic logic [dcspi_pkg::GAIN_W-1:0] pick_gain();
    return ($urandom_range(0, 1) == 0) ? dcspi_pkg::GAIN_W'($urandom_range(0, 600))
                                       : dcspi_pkg::GAIN_W'($urandom);
  endfunction

  task automatic send_sample(input logic ch, input logic signed [dcspi_pkg::SPEED_W-1:0] spd,
                             input logic signed [dcspi_pkg::SPEED_W-1:0] tgt,
                             input bit known,
                             input logic signed [dcspi_pkg::DRIVE_W-1:0] typed);
    int gap;
    logic signed [dcspi_pkg::DRIVE_W-1:0] pred;
    gap = tx_gaps ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.func   <= ch;
    in_if.speed  <= spd;
    in_if.target <= tgt;
    do @(posedge clk); while (!in_if.ready);
    // the state update happens regardless of whether the drive is typed in
    pred = predict_drive(ch, spd, tgt);
    drive_q.push_back(known ? typed : pred);
    samples_sent++;
  endtask

  task automatic drain_pipeline();
    in_if.valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  task automatic pick_sample(output logic ch, output logic signed [dcspi_pkg::SPEED_W-1:0] spd,
                             output logic signed [dcspi_pkg::SPEED_W-1:0] tgt);
    int kind;
    kind = $urandom_range(0, 9);
    ch   = 1'($urandom);
    spd  = dcspi_pkg::SPEED_W'($urandom);
    tgt  = dcspi_pkg::SPEED_W'($urandom);
    case (kind)
      3, 4, 5, 6: tgt = spd + dcspi_pkg::SPEED_W'($urandom_range(0, 600) - 300);
      7: begin
        spd = ($urandom_range(0, 1) == 0) ? SPD_MIN : SPD_MAX;
        tgt = ($urandom_range(0, 1) == 0) ? SPD_MIN : SPD_MAX;
      end
      8: tgt = spd;
      9: tgt = spd + dcspi_pkg::SPEED_W'($urandom_range(0, 16000) - 8000);
      default: ;
    endcase
  endtask

  task automatic run_random(input int count);
    logic ch;
    logic signed [dcspi_pkg::SPEED_W-1:0] spd, tgt;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) {tx_gaps, rx_gaps} = 2'($urandom);
      if ($urandom_range(0, 49) == 0) drain_pipeline();
      pick_sample(ch, spd, tgt);
      send_sample(ch, spd, tgt, 1'b0, '0);
    end
  endtask

  // Hammer one channel with the most negative error until the integral floors
  task automatic run_windup(input int count);
    logic ch;
    ch = 1'($urandom);
    for (int n = 0; n < count; n++) send_sample(ch, SPD_MAX, SPD_MIN, 1'b0, '0);
  endtask

  // Result side: random stall before each transfer
  initial begin
    int stall;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = rx_gaps ? $urandom_range(0, 16) : 0;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  always @(posedge clk) begin
    logic signed [dcspi_pkg::DRIVE_W-1:0] want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (drive_q.size() == 0) begin
        flag_error($sformatf("drive %0d with no sample pending", out_if.drive));
      end else begin
        want = drive_q.pop_front();
        if (out_if.drive !== want)
          flag_error($sformatf("drive #%0d: expected %0d, got %0d",
                               drives_checked, want, out_if.drive));
      end
      drives_checked++;
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int waited;
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_idx      <= '0;
    cfg_wdata    <= '0;
    in_if.valid  <= 1'b0;
    in_if.func   <= '0;
    in_if.speed  <= '0;
    in_if.target <= '0;
    gain_p_q      = dcspi_pkg::GAIN_P_RST;
    gain_i_q      = dcspi_pkg::GAIN_I_RST;
    gain_d_q      = dcspi_pkg::GAIN_D_RST;
    bias_first_q  = dcspi_pkg::BIAS_FIRST_RST;
    bias_second_q = dcspi_pkg::BIAS_SECOND_RST;
    for (int c = 0; c < dcspi_pkg::CHANNELS; c++) begin
      integ_q[c] = '0;
      last_q[c]  = '0;
      prior_q[c] = '0;
    end
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (opening_rows[r])
      send_sample(opening_rows[r].func, opening_rows[r].speed, opening_rows[r].target,
                  opening_rows[r].known, opening_rows[r].drive);
    drain_pipeline();

    // zero gains leave only the bias
    apply_settings('0, '0, '0, 8'sh80, 8'sh7F);
    {tx_gaps, rx_gaps} = 2'b00;
    run_random(100);
    drain_pipeline();

    apply_settings('1, '1, '1, 8'sh7F, 8'sh80);
    run_random(100);
    drain_pipeline();

    // writes to unmapped indexes must not disturb anything
    for (int i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++)
      cfg_write(dcspi_pkg::CFG_IDX_W'(i), dcspi_pkg::CFG_DATA_W'($urandom));
    apply_settings(dcspi_pkg::GAIN_P_RST, dcspi_pkg::GAIN_I_RST, 12'd300,
                   8'($urandom), 8'($urandom));
    run_windup(135);
    run_random(60);
    drain_pipeline();

    repeat (4) begin
      apply_settings(pick_gain(), pick_gain(), pick_gain(), 8'($urandom), 8'($urandom));
      run_random(110);
      drain_pipeline();
    end

    in_if.valid <= 1'b0;
    waited = 0;
    while (drive_q.size() != 0 && waited < END_WAIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (PIPE_LAT + 4) @(posedge clk);
    if (drive_q.size() != 0)
      flag_error($sformatf("%0d drives never arrived", drive_q.size()));

    $display("Covered %0d samples on both channels under %0d gain/bias settings, %0d drives checked.",
             samples_sent, settings_cnt + 1, drives_checked);
    $display("Clamped drives: %0d, integral floor saturations: %0d, mismatches: %0d.",
             clamp_hits, floor_hits, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/dcspi_pkg.sv
rtl/dcspi_if.sv
rtl/dual_channel_speed_pi_controller_unit.sv
tb/tb.sv
